[src/energy_voice_activity_detector_defines.svh]
// Assertion macros for the energy voice activity detector.
// Included by files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_DEFINES_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_DEFINES_SVH

// same-cycle implication
`define EVAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EVAD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/evad_pkg.sv]
// Shared types and constants of the energy voice activity detector.
// No dependencies.
package evad_pkg;

  localparam int unsigned LEN_BITS    = 16;
  localparam int unsigned MAG_BITS    = 11;
  localparam int unsigned SQ_BITS     = 2 * MAG_BITS;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_LEN     = 2'd2;

  localparam logic             MODE_8BIT      = 1'b0;
  localparam logic             MODE_RESET     = 1'b1;
  localparam logic [63:0]      THRESH_RESET   = 64'd3000000;
  localparam logic [LEN_BITS-1:0] WIN_LEN_RESET = 16'd4096;

  typedef struct packed {
    logic                 empty;
    logic [QCNT_BITS-1:0] count;
  } q_stat_t;

endpackage

[src/evad_queue.sv]
// Short queue of closed-window energies between front and back.
// Depends on evad_pkg.
module evad_queue #(
  parameter int unsigned W = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [W-1:0]      push_data_i,
  input  logic              pop_i,
  output logic [W-1:0]      head_o,
  output evad_pkg::q_stat_t stat_o
);

  logic [W-1:0] mem [evad_pkg::QUEUE_DEPTH];
  logic [evad_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [evad_pkg::QCNT_BITS-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + evad_pkg::QCNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - evad_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + evad_pkg::QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + evad_pkg::QPTR_BITS'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.count = count_q;

endmodule

[src/evad_front.sv]
// Front end: takes samples, squares the scaled magnitude, accumulates the window.
// Pushes the saturated window energy into the queue. Depends on evad_pkg.
module evad_front #(
  parameter int unsigned SUM_BITS = 40
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [15:0]                   sample_raw_i,
  input  logic                          sample_mode_i,
  input  logic [evad_pkg::LEN_BITS-1:0] window_length_i,
  input  evad_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output logic [SUM_BITS-1:0]           push_data_o
);

  localparam int unsigned LB = evad_pkg::LEN_BITS;
  localparam int unsigned MB = evad_pkg::MAG_BITS;
  localparam int unsigned SB = evad_pkg::SQ_BITS;

  logic          accept;
  logic [MB-1:0] mag;
  logic [16:0]   neg_w;
  logic [LB:0]   sc_next;
  logic          close_now;
  logic [SUM_BITS:0] sum_add;
  logic [SUM_BITS-1:0] sum_sat;

  logic          vld_q;
  logic          close_q;
  logic [SB-1:0] sq_q;
  logic [LB-1:0] sc_q;
  logic [SUM_BITS-1:0] sum_q;

  assign in_stall_o = ({1'b0, q_stat_i.count} + (evad_pkg::QCNT_BITS + 1)'(vld_q))
                      >= (evad_pkg::QCNT_BITS + 1)'(evad_pkg::QUEUE_DEPTH);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    neg_w = 17'h10000 - {1'b0, sample_raw_i};
    if (sample_mode_i == evad_pkg::MODE_8BIT) begin
      if (sample_raw_i[7]) begin
        mag = MB'({1'b0, sample_raw_i[6:0]});
      end else begin
        mag = MB'(9'd128 - {1'b0, sample_raw_i[7:0]});
      end
    end else if (sample_raw_i[15]) begin
      mag = neg_w[5+MB-1:5];
    end else begin
      mag = MB'(sample_raw_i[14:5]);
    end
  end

  assign sc_next   = {1'b0, sc_q} + (LB + 1)'(1);
  assign close_now = !(sc_next < {1'b0, window_length_i});

  assign sum_add = {1'b0, sum_q} + (SUM_BITS + 1)'(sq_q);
  assign sum_sat = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      close_q <= 1'b0;
      sc_q    <= '0;
      sum_q   <= '0;
    end else begin
      vld_q <= accept;
      if (accept) begin
        close_q <= close_now;
        sc_q    <= close_now ? '0 : sc_next[LB-1:0];
      end
      if (vld_q) begin
        sum_q <= close_q ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q <= SB'(mag * mag);
    end
  end

  assign push_o      = vld_q && close_q;
  assign push_data_o = sum_sat;

endmodule

[src/evad_back.sv]
// Back end: threshold decision, hangover counters and the result register.
// Depends on evad_pkg.
module evad_back #(
  parameter int unsigned SUM_BITS   = 40,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  evad_pkg::q_stat_t     q_stat_i,
  input  logic [SUM_BITS-1:0]   head_i,
  output logic                  pop_o,
  input  logic [SUM_BITS-1:0]   energy_threshold_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SUM_BITS-1:0]   window_energy_o,
  output logic                  voiced_now_o,
  output logic                  speaking_report_o,
  output logic                  silence_report_o,
  output logic [COUNT_BITS-1:0] talk_windows_o,
  output logic [COUNT_BITS-1:0] quiet_windows_o
);

  localparam int unsigned CB = COUNT_BITS;

  function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CB] ? {CB{1'b1}} : s[CB-1:0];
  endfunction

  logic [CB-1:0] talk_q, quiet_q;
  logic          out_valid_q;
  logic          voiced, silence, speaking;
  logic [CB-1:0] t1, q1, t2, q2, t_d, q_d;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    voiced   = head_i >= energy_threshold_i;
    t1       = voiced ? sat_add(talk_q, CB'(1)) : talk_q;
    q1       = voiced ? quiet_q : sat_add(quiet_q, CB'(1));
    silence  = (t1 == '0) || (q1 > CB'(2));
    t2       = silence ? '0 : t1;
    speaking = voiced || ((t2 != '0) && (q1 <= CB'(2)));
    q2       = speaking ? '0 : q1;
    if (voiced && (q2 < CB'(2))) begin
      t_d = sat_add(t2, q2);
      q_d = '0;
    end else begin
      t_d = t2;
      q_d = q2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      talk_q      <= '0;
      quiet_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        talk_q  <= t_d;
        quiet_q <= q_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      window_energy_o   <= head_i;
      voiced_now_o      <= voiced;
      speaking_report_o <= speaking;
      silence_report_o  <= silence;
      talk_windows_o    <= t_d;
      quiet_windows_o   <= q_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/energy_voice_activity_detector.sv]
// Energy voice activity detector top level: config registers, front, queue, back.
// Throughput one sample per cycle while in_stall_o is low; a filling queue raises it.
// A window-closing beat passes the front registers and the queue to the back's result.
// Reset clears sum, sample and hangover counters and loads the register defaults.
// Depends on evad_pkg, evad_front, evad_queue, evad_back and the defines header.
`include "energy_voice_activity_detector_defines.svh"

module energy_voice_activity_detector #(
  parameter int unsigned SUM_BITS   = 40,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [evad_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [SUM_BITS-1:0]               cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [15:0]                       sample_raw_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [SUM_BITS-1:0]               window_energy_o,
  output logic                              voiced_now_o,
  output logic                              speaking_report_o,
  output logic                              silence_report_o,
  output logic [COUNT_BITS-1:0]             talk_windows_o,
  output logic [COUNT_BITS-1:0]             quiet_windows_o
);

  logic                          mode_q;
  logic [SUM_BITS-1:0]           thresh_q;
  logic [evad_pkg::LEN_BITS-1:0] win_len_q;

  logic                push;
  logic [SUM_BITS-1:0] push_data;
  logic                pop;
  logic [SUM_BITS-1:0] head;
  evad_pkg::q_stat_t   q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= evad_pkg::MODE_RESET;
      thresh_q  <= SUM_BITS'(evad_pkg::THRESH_RESET);
      win_len_q <= evad_pkg::WIN_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        evad_pkg::CFG_SAMPLE_MODE: mode_q    <= cfg_wdata_i[0];
        evad_pkg::CFG_THRESHOLD:   thresh_q  <= cfg_wdata_i;
        evad_pkg::CFG_WIN_LEN:     win_len_q <= cfg_wdata_i[evad_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  evad_front #(
    .SUM_BITS(SUM_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_raw_i   (sample_raw_i),
    .sample_mode_i  (mode_q),
    .window_length_i(win_len_q),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  evad_queue #(
    .W(SUM_BITS)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  evad_back #(
    .SUM_BITS  (SUM_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_stat_i          (q_stat),
    .head_i            (head),
    .pop_o             (pop),
    .energy_threshold_i(thresh_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .window_energy_o   (window_energy_o),
    .voiced_now_o      (voiced_now_o),
    .speaking_report_o (speaking_report_o),
    .silence_report_o  (silence_report_o),
    .talk_windows_o    (talk_windows_o),
    .quiet_windows_o   (quiet_windows_o)
  );

  `EVAD_ASSERT_NOW(a_silence_clears_talk, out_valid_o && silence_report_o, talk_windows_o == '0, "silence with nonzero talk count")
  `EVAD_ASSERT_NOW(a_speaking_clears_quiet, out_valid_o && speaking_report_o, quiet_windows_o == '0, "speaking with nonzero quiet count")
  `EVAD_ASSERT_NOW(a_voiced_is_speaking, out_valid_o && voiced_now_o, speaking_report_o, "voiced window not reported as speaking")
  `EVAD_ASSERT_NXT(a_queue_drains, !q_stat.empty && !out_valid_o, out_valid_o, "queued window not moved to output")

endmodule
